// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file of the parser block.
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define RPTS_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Consequent checked in the cycle after the antecedent.
`define RPTS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/rpts_pkg.sv =====
// Package of the readout packet timestamp parser: constants, register
// indexes and the structs passed between its modules. No dependencies.
`default_nettype none

package rpts_pkg;

    localparam logic [7:0] SYNC_BYTE    = 8'hCD;
    localparam logic [7:0] HDR_KIND     = 8'h10;
    localparam logic [7:0] HDR_LEN_HI   = 8'h00;
    localparam logic [7:0] HDR_LAST     = 8'h08;
    localparam logic [7:0] MAGIC_E      = 8'h45;
    localparam logic [7:0] MAGIC_M      = 8'h4D;
    localparam logic [7:0] MAGIC_I      = 8'h49;
    localparam logic [7:0] MAGIC_T      = 8'h54;
    localparam logic [7:0] TRAIL_BYTE   = 8'hAB;
    localparam logic [7:0] TYPE_START   = 8'h01;
    localparam logic [7:0] TYPE_DATA    = 8'h10;
    localparam logic [15:0] MAGIC_SKIP  = 16'd8;

    localparam logic [7:0] BACKOFF_RST  = 8'd10;
    localparam logic [7:0] JUMP_LIM_RST = 8'd50;

    // Configuration register indexes.
    localparam logic CFG_IDX_BACKOFF  = 1'b0;
    localparam logic CFG_IDX_JUMP_LIM = 1'b1;

    typedef struct packed {
        logic [7:0] roc_backoff;
        logic [7:0] roc_jump_limit;
    } cfg_t;

    typedef struct packed {
        logic        valid;
        logic [31:0] readout_cycle;
        logic [47:0] timestamp;
        logic [15:0] trigger_id;
        logic        roc_jump_error;
    } result_t;

endpackage

`default_nettype wire

// ===== rtl/rpts_cfg_regs.sv =====
// Configuration registers of the parser: cycle backoff and jump limit.
// Depends on rpts_pkg for register indexes and reset values.
`default_nettype none

module rpts_cfg_regs
    import rpts_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_write_en,
    input  wire logic       cfg_index,
    input  wire logic [7:0] cfg_data,
    output cfg_t            cfg
);

    logic [7:0] backoff_reg;
    logic [7:0] jump_lim_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            backoff_reg  <= BACKOFF_RST;
            jump_lim_reg <= JUMP_LIM_RST;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                CFG_IDX_BACKOFF:  backoff_reg  <= cfg_data;
                CFG_IDX_JUMP_LIM: jump_lim_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    assign cfg.roc_backoff    = backoff_reg;
    assign cfg.roc_jump_limit = jump_lim_reg;

endmodule

`default_nettype wire

// ===== rtl/rpts_parser.sv =====
// Packet parser state machine: sync hunt, header, magic and trailer blocks,
// skipping and the readout cycle count. Depends on rpts_pkg.
`default_nettype none

module rpts_parser
    import rpts_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       step,
    input  wire logic [7:0] data_byte,
    input  wire cfg_t       cfg,
    output result_t         res
);

    typedef enum logic [2:0] {
        PH_SYNC1   = 3'd0,
        PH_SYNC2   = 3'd1,
        PH_HEADER  = 3'd2,
        PH_MAGIC   = 3'd3,
        PH_TRAILER = 3'd4,
        PH_SKIP    = 3'd5
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [2:0]  idx_reg, idx_next;
    logic [15:0] skip_reg, skip_next;
    logic [15:0] len_reg, len_next;
    logic        ok_reg, ok_next;
    logic [7:0]  cyc_byte_reg, cyc_byte_next;
    logic [7:0]  type_reg, type_next;
    logic [15:0] trig_reg, trig_next;
    logic [47:0] stamp_reg, stamp_next;
    logic [31:0] count_reg, count_next;

    logic        last;
    logic [15:0] skip_dec;
    logic [31:0] back_val;
    logic [31:0] back_adj;
    logic [7:0]  inc;

    assign last     = (idx_reg == 3'd7);
    assign skip_dec = (skip_reg != 16'd0) ? skip_reg - 16'd1 : skip_reg;
    // Re-extension: step back by the backoff, then move up one wrap of the
    // low byte if the stepped-back low byte lies above the received byte.
    assign back_val = count_reg - {24'd0, cfg.roc_backoff};
    assign back_adj = (back_val[7:0] > cyc_byte_reg) ? back_val + 32'd256 : back_val;
    assign inc      = cyc_byte_reg - count_reg[7:0];

    always_comb
    begin
        phase_next    = phase_reg;
        idx_next      = idx_reg;
        skip_next     = skip_reg;
        len_next      = len_reg;
        ok_next       = ok_reg;
        cyc_byte_next = cyc_byte_reg;
        type_next     = type_reg;
        trig_next     = trig_reg;
        stamp_next    = stamp_reg;
        count_next    = count_reg;
        res           = '0;

        unique case (phase_reg)
            PH_SYNC1:
            begin
                if (data_byte == SYNC_BYTE)
                    phase_next = PH_SYNC2;
            end
            PH_SYNC2:
            begin
                if (data_byte == SYNC_BYTE)
                begin
                    phase_next = PH_HEADER;
                    idx_next   = 3'd0;
                    ok_next    = 1'b1;
                end
                else
                    phase_next = PH_SYNC1;
            end
            PH_HEADER:
            begin
                if (idx_reg == 3'd0)
                begin
                    len_next = {8'd0, data_byte};
                    ok_next  = (data_byte == HDR_KIND);
                end
                else if (idx_reg == 3'd1)
                begin
                    len_next = {data_byte, len_reg[7:0]};
                    ok_next  = ok_reg && (data_byte == HDR_LEN_HI);
                end
                else if (idx_reg == 3'd2)
                    cyc_byte_next = data_byte;
                idx_next = idx_reg + 3'd1;
                if (last)
                begin
                    if (ok_reg && (data_byte == HDR_LAST))
                        phase_next = PH_MAGIC;
                    else
                    begin
                        skip_next  = len_reg;
                        phase_next = (len_reg == 16'd0) ? PH_SYNC1 : PH_SKIP;
                    end
                end
            end
            PH_MAGIC:
            begin
                unique case (idx_reg)
                    3'd0:    ok_next = (data_byte == MAGIC_E);
                    3'd1:    ok_next = ok_reg && (data_byte == MAGIC_M);
                    3'd2:    ok_next = ok_reg && (data_byte == MAGIC_I);
                    3'd3:    ok_next = ok_reg && (data_byte == MAGIC_T);
                    3'd4:    type_next = data_byte;
                    3'd6:    trig_next = {8'd0, data_byte};
                    3'd7:    trig_next = {data_byte, trig_reg[7:0]};
                    default: ;
                endcase
                idx_next = idx_reg + 3'd1;
                if (last)
                begin
                    if (ok_reg)
                        phase_next = PH_TRAILER;
                    else
                    begin
                        ok_next    = 1'b1;
                        skip_next  = MAGIC_SKIP;
                        phase_next = PH_SKIP;
                    end
                end
            end
            PH_TRAILER:
            begin
                // Bytes 0 to 5 each land once, so byte 0 clears the rest.
                if (idx_reg == 3'd0)
                    stamp_next = {40'd0, data_byte};
                else if (idx_reg < 3'd6)
                    stamp_next[8*idx_reg +: 8] = data_byte;
                else if (idx_reg == 3'd6)
                    ok_next = (data_byte == TRAIL_BYTE);
                idx_next = idx_reg + 3'd1;
                if (last)
                begin
                    phase_next = PH_SYNC1;
                    ok_next    = 1'b1;
                    if (ok_reg && (data_byte == TRAIL_BYTE))
                    begin
                        if (type_reg == TYPE_START)
                            count_next = {back_adj[31:8], cyc_byte_reg};
                        else if (type_reg == TYPE_DATA)
                        begin
                            count_next         = count_reg + {24'd0, inc};
                            res.valid          = 1'b1;
                            res.readout_cycle  = count_reg + {24'd0, inc};
                            res.timestamp      = stamp_reg;
                            res.trigger_id     = trig_reg;
                            res.roc_jump_error = (inc > cfg.roc_jump_limit);
                        end
                    end
                end
            end
            PH_SKIP:
            begin
                skip_next = skip_dec;
                if (skip_dec == 16'd0)
                    phase_next = PH_SYNC1;
            end
            default:
            begin
                phase_next = PH_SYNC1;
                idx_next   = 3'd0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_SYNC1;
            idx_reg      <= 3'd0;
            skip_reg     <= 16'd0;
            len_reg      <= 16'd0;
            ok_reg       <= 1'b1;
            cyc_byte_reg <= 8'd0;
            type_reg     <= 8'd0;
            trig_reg     <= 16'd0;
            stamp_reg    <= 48'd0;
            count_reg    <= 32'd0;
        end
        else if (step)
        begin
            phase_reg    <= phase_next;
            idx_reg      <= idx_next;
            skip_reg     <= skip_next;
            len_reg      <= len_next;
            ok_reg       <= ok_next;
            cyc_byte_reg <= cyc_byte_next;
            type_reg     <= type_next;
            trig_reg     <= trig_next;
            stamp_reg    <= stamp_next;
            count_reg    <= count_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/rpts_out_stage.sv =====
// Result register of the parser with the output valid/stall handshake.
// Depends on rpts_pkg for the result struct.
`default_nettype none

module rpts_out_stage
    import rpts_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        load,
    input  wire result_t     res,
    output logic             advance,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [31:0]      readout_cycle,
    output logic [47:0]      timestamp,
    output logic [15:0]      trigger_id,
    output logic             roc_jump_error
);

    logic        valid_reg;
    logic [31:0] cycle_reg;
    logic [47:0] stamp_reg;
    logic [15:0] trig_reg;
    logic        err_reg;

    // The register may take a new word when it is empty or being drained.
    assign advance = !valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (advance)
            valid_reg <= load && res.valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance && load && res.valid)
        begin
            cycle_reg <= res.readout_cycle;
            stamp_reg <= res.timestamp;
            trig_reg  <= res.trigger_id;
            err_reg   <= res.roc_jump_error;
        end
    end

    assign out_valid      = valid_reg;
    assign readout_cycle  = cycle_reg;
    assign timestamp      = stamp_reg;
    assign trigger_id     = trig_reg;
    assign roc_jump_error = err_reg;

endmodule

`default_nettype wire

// ===== rtl/readout_packet_timestamp_parser_core.sv =====
// Readout packet timestamp parser, top level.
// One byte per cycle while the input is not stalled; a record reaches the outputs after its last
// trailer byte is accepted into the input register and the result register then catches
// the parser output.
// Input stalls only while a finished record waits in the result register.
// Asynchronous active-low reset: sync hunt, count zero, backoff 10, jump limit 50.
// Depends on rpts_pkg, rpts_cfg_regs, rpts_parser and rpts_out_stage.
`default_nettype none

module readout_packet_timestamp_parser_core
    import rpts_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_write_en,
    input  wire logic        cfg_index,
    input  wire logic [7:0]  cfg_data,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  data_byte,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [31:0]      readout_cycle,
    output logic [47:0]      timestamp,
    output logic [15:0]      trigger_id,
    output logic             roc_jump_error
);

    cfg_t       cfg;
    result_t    res;
    logic       advance;
    logic       in_valid_reg;
    logic [7:0] byte_reg;
    logic       step;

    rpts_cfg_regs u_cfg (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cfg          (cfg)
    );

    assign step     = in_valid_reg && advance;
    assign in_stall = in_valid_reg && !advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (!in_stall)
            in_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall)
            byte_reg <= data_byte;
    end

    rpts_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .data_byte (byte_reg),
        .cfg       (cfg),
        .res       (res)
    );

    rpts_out_stage u_out (
        .clk            (clk),
        .rst_n          (rst_n),
        .load           (step),
        .res            (res),
        .advance        (advance),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .readout_cycle  (readout_cycle),
        .timestamp      (timestamp),
        .trigger_id     (trigger_id),
        .roc_jump_error (roc_jump_error)
    );

endmodule

`default_nettype wire

// ===== rtl/rpts_checker.sv =====
// Port-level checker for the parser top level, bound to it below.
// Depends on assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module rpts_checker
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_stall,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic [31:0] readout_cycle,
    input wire logic [47:0] timestamp
);

    // A stalled record stays offered.
    `RPTS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)
    // A stalled record keeps its payload.
    `RPTS_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(readout_cycle) && $stable(timestamp))
    // The input side only backs up behind a waiting record.
    `RPTS_ASSERT_SAME(a_stall_cause, in_stall, out_valid && out_stall)
    // A new record follows a byte accepted at the input, passed through the input and result registers.
    `RPTS_ASSERT_SAME(a_rec_source, $rose(out_valid), $past(in_valid && !in_stall, 2))

endmodule

bind readout_packet_timestamp_parser_core rpts_checker u_rpts_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .readout_cycle (readout_cycle),
    .timestamp     (timestamp)
);

`default_nettype wire
